// ===== sv/cts_pkg.sv =====
// shared types and constants for the cooperative thread slot scheduler
// no dependencies
`timescale 1ns / 1ps
package cts_pkg;
   localparam int SlotBits = 3;
   localparam int TickBits = 32;

   typedef enum logic [2:0] {
      ACT_CREATE  = 3'd0,
      ACT_DISPATCH = 3'd1,
      ACT_YIELD   = 3'd2,
      ACT_IDLE    = 3'd3,
      ACT_WAIT    = 3'd4,
      ACT_NOTIFY1 = 3'd5,
      ACT_NOTIFYA = 3'd6,
      ACT_EXIT    = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      STS_OK   = 2'd0,
      STS_FULL = 2'd1,
      STS_IDLE = 2'd2,
      STS_NONE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SL_EMPTY = 3'd0,
      SL_NEW   = 3'd1,
      SL_RUN   = 3'd2,
      SL_IDLE  = 3'd3,
      SL_WAIT  = 3'd4
   } slot_state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] now_tick;
      logic [31:0] wait_ticks;
      logic [7:0]  sem_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  slot;
      logic        resumed_notified;
      logic [31:0] sleep_ticks;
      logic [3:0]  woken_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic update;    // apply current-slot update
      logic notify;    // step one slot for notify
      logic sweep;     // step one slot of the wake sweep
      logic scan;      // step one slot of the round-robin pick
      logic scan_init; // reset step counter
      logic finish;    // drive result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_create;
      logic is_notify;
      logic no_threads;
      logic need_sweep;
      logic last_step;
      logic found;
      logic stop_notify;
   } sts_type;
endpackage

// ===== sv/coop_thread_slot_scheduler.sv =====
// scheduler top: one item per start, result strobed once on rsp_valid
// a create goes through update and done; a notify steps the slots after update; a pick goes
// through decide and scan, with a wake sweep and a post check before the scan when all sleep; one slot per cycle
// a new item can be accepted in the strobe cycle; the receiver cannot stall
// synchronous reset empties all slots and sets the current slot to the last one
`timescale 1ns / 1ps
module coop_thread_slot_scheduler
   import cts_pkg::*;
#(
   parameter int MAX_THREADS = 8,
   parameter int TICK_WIDTH  = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);
   ctl_type ctl, ctl_q;
   sts_type sts;
   logic    fsm_busy;
   logic    dp_valid;
   rsp_type rsp_int;

   cts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(fsm_busy),
      .ctl(ctl), .sts(sts)
   );

   assign ctl_q = ctl;

   cts_dp #(.MAX_THREADS(MAX_THREADS), .TICK_WIDTH(TICK_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .req(req_item), .ctl(ctl_q), .sts(sts),
      .rsp_valid(dp_valid), .rsp(rsp_int)
   );

   assign busy      = fsm_busy;
   assign rsp_valid = dp_valid;
   assign rsp_item  = rsp_int;
endmodule

// ===== sv/cts_ctrl.sv =====
// controller state machine of the scheduler
// depends on cts_pkg
`timescale 1ns / 1ps
module cts_ctrl
   import cts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output ctl_type ctl,
   input  sts_type sts
);
   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_UPDATE = 8'b00000010,
      S_NOTIFY = 8'b00000100,
      S_SWEEP  = 8'b00001000,
      S_SCAN   = 8'b00010000,
      S_DONE   = 8'b00100000,
      S_DECIDE = 8'b01000000,
      S_POST   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            ctl.update = 1'b1;
            ctl.scan_init = 1'b1;
            if (sts.is_create) state_in = S_DONE;
            else if (sts.is_notify) state_in = S_NOTIFY;
            else state_in = S_DECIDE;
         end
         S_DECIDE: begin
            ctl.scan_init = 1'b1;
            if (sts.no_threads) state_in = S_DONE;
            else if (sts.need_sweep) state_in = S_SWEEP;
            else state_in = S_SCAN;
         end
         S_NOTIFY: begin
            ctl.notify = 1'b1;
            if (sts.last_step || sts.stop_notify) state_in = S_DONE;
         end
         S_SWEEP: begin
            ctl.sweep = 1'b1;
            if (sts.last_step) state_in = S_POST;
         end
         // still all asleep after the sweep: report idle, else pick
         S_POST: begin
            ctl.scan_init = 1'b1;
            if (sts.need_sweep) state_in = S_DONE;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.last_step || sts.found) state_in = S_DONE;
         end
         S_DONE: begin
            ctl.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
endmodule

// ===== sv/cts_dp.sv =====
// slot table and per-item datapath of the scheduler
// depends on cts_pkg
`timescale 1ns / 1ps
module cts_dp
   import cts_pkg::*;
#(
   parameter int MAX_THREADS = 8,
   parameter int TICK_WIDTH  = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  ctl_type ctl,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp
);
   localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CW = $clog2(MAX_THREADS + 1);
   localparam logic [IW-1:0] LAST = IW'(MAX_THREADS - 1);
   localparam logic [TICK_WIDTH-1:0] TMAX = '1;

   slot_state_type          st_ff   [MAX_THREADS];
   logic [TICK_WIDTH-1:0]   wake_ff [MAX_THREADS];
   logic [7:0]              sem_ff  [MAX_THREADS];
   logic                    inf_ff  [MAX_THREADS];
   logic                    ntf_ff  [MAX_THREADS];
   logic [IW-1:0]           cur_ff;
   logic [CW-1:0]           busy_ff, sleep_ff;

   req_type                 req_ff;
   logic [IW-1:0]           step_ff, idx_ff;
   logic [TICK_WIDTH-1:0]   min_ff;
   logic [3:0]              woken_ff;
   logic [1:0]              status_ff;
   logic [2:0]              slot_ff;
   logic                    rn_ff;
   logic                    valid_ff;

   logic [TICK_WIDTH-1:0] now, span;
   assign now  = TICK_WIDTH'(req_ff.now_tick);
   assign span = TICK_WIDTH'(req_ff.wait_ticks);

   logic running;
   assign running = (st_ff[cur_ff] == SL_NEW) || (st_ff[cur_ff] == SL_RUN);

   // lowest empty slot for create
   logic [IW-1:0] free_idx;
   always_comb begin
      free_idx = '0;
      for (int i = MAX_THREADS - 1; i >= 0; i--)
         if (st_ff[i] == SL_EMPTY) free_idx = IW'(i);
   end

   // slot under examination this step
   logic [IW-1:0] scan_idx;
   always_comb begin
      if (ctl.scan) scan_idx = (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
      else scan_idx = step_ff;
   end

   slot_state_type sst;
   logic timed, over, ready;
   logic [TICK_WIDTH-1:0] left, since;
   assign sst   = st_ff[scan_idx];
   assign timed = (sst == SL_IDLE) || (sst == SL_WAIT && !inf_ff[scan_idx]);
   assign since = now - wake_ff[scan_idx];
   assign over  = !since[TICK_WIDTH-1];
   assign left  = wake_ff[scan_idx] - now;
   assign ready = (sst == SL_RUN) || (sst == SL_NEW) || (timed && over);
   logic notify_hit;
   assign notify_hit = (sst == SL_WAIT) && (sem_ff[scan_idx] == req_ff.sem_id);

   action_type act;
   assign act = action_type'(req_ff.action);

   assign sts.is_create   = (act == ACT_CREATE);
   assign sts.is_notify   = (act == ACT_NOTIFY1) || (act == ACT_NOTIFYA);
   assign sts.no_threads  = (busy_ff == '0);
   assign sts.need_sweep  = (sleep_ff != '0) && (busy_ff <= sleep_ff);
   assign sts.last_step   = (step_ff == LAST);
   assign sts.found       = ready;
   assign sts.stop_notify = notify_hit && (act == ACT_NOTIFY1);

   // sleeping count less one, for a slot woken by notify, sweep or pick; the sweep uses it to decide idle vs pick
   logic [CW-1:0] sleep_dec;
   assign sleep_dec = (sleep_ff != '0) ? sleep_ff - 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_THREADS; i++) begin
            st_ff[i]   <= SL_EMPTY;
            wake_ff[i] <= '0;
            sem_ff[i]  <= '0;
            inf_ff[i]  <= 1'b0;
            ntf_ff[i]  <= 1'b0;
         end
         cur_ff   <= LAST;
         busy_ff  <= '0;
         sleep_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.finish;
         if (ctl.load) begin
            req_ff    <= req;
            woken_ff  <= '0;
            status_ff <= STS_OK;
            slot_ff   <= '0;
            rn_ff     <= 1'b0;
            min_ff    <= TMAX;
         end
         if (ctl.scan_init) begin
            step_ff <= '0;
            idx_ff  <= cur_ff;
         end
         if (ctl.update) begin
            unique case (act)
               ACT_CREATE: begin
                  if (busy_ff >= CW'(MAX_THREADS)) status_ff <= STS_FULL;
                  else begin
                     st_ff[free_idx]   <= SL_NEW;
                     wake_ff[free_idx] <= '0;
                     sem_ff[free_idx]  <= '0;
                     inf_ff[free_idx]  <= 1'b0;
                     ntf_ff[free_idx]  <= 1'b0;
                     busy_ff <= busy_ff + 1'b1;
                     slot_ff <= 3'(free_idx);
                  end
               end
               ACT_YIELD, ACT_IDLE: begin
                  if (running) begin
                     ntf_ff[cur_ff] <= 1'b0;
                     if (act == ACT_IDLE && span != '0) begin
                        st_ff[cur_ff]   <= SL_IDLE;
                        wake_ff[cur_ff] <= now + span;
                        sleep_ff        <= sleep_ff + 1'b1;
                     end else st_ff[cur_ff] <= SL_RUN;
                  end
               end
               ACT_WAIT: begin
                  if (running) begin
                     sem_ff[cur_ff] <= req_ff.sem_id;
                     ntf_ff[cur_ff] <= 1'b0;
                     wake_ff[cur_ff] <= (span != '0) ? now + span : '0;
                     inf_ff[cur_ff]  <= (span == '0);
                     st_ff[cur_ff]   <= SL_WAIT;
                     sleep_ff        <= sleep_ff + 1'b1;
                  end
               end
               ACT_EXIT: begin
                  if (running) begin
                     st_ff[cur_ff]  <= SL_EMPTY;
                     ntf_ff[cur_ff] <= 1'b0;
                     if (busy_ff != '0) busy_ff <= busy_ff - 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (ctl.scan_init && !ctl.update && busy_ff == '0) begin
            cur_ff    <= LAST;
            status_ff <= STS_NONE;
         end
         if (ctl.notify) begin
            step_ff <= step_ff + 1'b1;
            if (notify_hit) begin
               ntf_ff[scan_idx] <= 1'b1;
               st_ff[scan_idx]  <= SL_RUN;
               sleep_ff <= sleep_dec;
               woken_ff <= woken_ff + 1'b1;
            end
         end
         if (ctl.sweep) begin
            step_ff <= step_ff + 1'b1;
            if (timed) begin
               if (over) begin
                  st_ff[scan_idx] <= SL_RUN;
                  sleep_ff <= sleep_dec;
               end else if (left < min_ff) min_ff <= left;
            end
            // last step: decide idle or a fresh pick
            if (step_ff == LAST) begin
               if ((timed && over ? sleep_dec : sleep_ff) != '0 &&
                   busy_ff <= (timed && over ? sleep_dec : sleep_ff)) begin
                  status_ff <= STS_IDLE;
               end else begin
                  // some slot woke: it is RUN, so pick the first ready after cur
                  status_ff <= STS_OK;
               end
            end
         end
         if (ctl.scan) begin
            step_ff <= step_ff + 1'b1;
            idx_ff  <= scan_idx;
            if (ready) begin
               if (sst != SL_RUN && sst != SL_NEW) begin
                  st_ff[scan_idx] <= SL_RUN;
                  sleep_ff <= sleep_dec;
               end
               cur_ff    <= scan_idx;
               status_ff <= STS_OK;
               slot_ff   <= 3'(scan_idx);
               rn_ff     <= ntf_ff[scan_idx];
            end else if (step_ff == LAST) status_ff <= STS_IDLE;
         end
      end
   end

   // after a sweep that woke a slot, a pick still follows
   logic sweep_woke_ff;
   always_ff @(posedge clock) begin
      if (reset) sweep_woke_ff <= 1'b0;
      else if (ctl.load) sweep_woke_ff <= 1'b0;
      else if (ctl.sweep && step_ff == LAST)
         sweep_woke_ff <= !(((timed && over) ? sleep_dec : sleep_ff) != '0 &&
                            busy_ff <= ((timed && over) ? sleep_dec : sleep_ff));
   end

   // second scan pass: a woken slot is RUN now, so the ready rule finds it
   assign rsp_valid = valid_ff;
   always_comb begin
      rsp = '0;
      rsp.status = status_ff;
      rsp.woken_count = woken_ff;
      if (status_ff == STS_OK) begin
         rsp.slot = slot_ff;
         rsp.resumed_notified = rn_ff;
      end
      if (status_ff == STS_IDLE && !sweep_woke_ff)
         rsp.sleep_ticks = (min_ff == TMAX) ? 32'd0 : 32'(min_ff);
      else if (status_ff == STS_IDLE) rsp.sleep_ticks = '0;
   end
endmodule

// ===== sv/cts_checker.sv =====
// port-level checks for the scheduler
// depends on cts_pkg; bound to coop_thread_slot_scheduler
`timescale 1ns / 1ps
module cts_checker
   import cts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_no_idle_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(busy)) |-> 1'b0) else $error("result without item");
   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STS_FULL) |-> rsp_item.slot == '0)
      else $error("full with slot");
endmodule

bind coop_thread_slot_scheduler cts_checker u_cts_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item)
);
